FILE: sv/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int MAPPED_W    = 23;
  localparam int ROM_BANK_W  = 9;
  localparam int ROM_COUNT_W = 10;
  localparam int RAM_COUNT_W = 5;
  localparam int RAM_BANK_W  = 4;
  localparam int NIBBLE_W    = 4;
  localparam int ROM_OFS_W   = 14;
  localparam int RAM_OFS_W   = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int STEP_W      = $clog2(ROM_BANK_W + 1);

  localparam logic [ADDR_W-1:0] ROM_LOW_LAST   = 16'h3FFF;
  localparam logic [ADDR_W-1:0] ROM_HIGH_LAST  = 16'h7FFF;
  localparam logic [ADDR_W-1:0] RAMEN_LAST     = 16'h1FFF;
  localparam logic [ADDR_W-1:0] BANK_LO_LAST   = 16'h2FFF;
  localparam logic [ADDR_W-1:0] BANK_HI_LAST   = 16'h3FFF;
  localparam logic [ADDR_W-1:0] RAM_BANK_LAST  = 16'h5FFF;
  localparam logic [DATA_W-1:0] RAM_BANK_MAX   = 8'h0F;
  localparam logic [NIBBLE_W-1:0] RAM_ENABLE_KEY = 4'hA;

  localparam logic [ROM_BANK_W-1:0]  ROM_BANK_RESET  = 9'd1;
  localparam logic [ROM_COUNT_W-1:0] ROM_COUNT_RESET = 10'd2;
  localparam logic [RAM_COUNT_W-1:0] RAM_COUNT_RESET = 5'd0;

  typedef enum logic [1:0] {
    ACT_ROM_READ  = 2'd0,
    ACT_ROM_WRITE = 2'd1,
    ACT_RAM_READ  = 2'd2,
    ACT_RAM_WRITE = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROM_BANK_COUNT = 2'd0,
    CFG_RAM_BANK_COUNT = 2'd1,
    CFG_RUMBLE_PRESENT = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    action_t           action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [MAPPED_W-1:0] mapped_address;
    logic                granted;
    logic                rumble_on;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: sv/cbm_mod_unit.sv
// ----------------------------------------------------------------------------
// cbm_mod_unit
// Restoring remainder unit: one compare and subtract per cycle, one
// dividend bit per step.
// ----------------------------------------------------------------------------
module cbm_mod_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [cbm_pkg::ROM_BANK_W-1:0]      dividend,
  input  logic [cbm_pkg::ROM_COUNT_W-1:0]     divisor,
  output cbm_pkg::div_status_t                status,
  output logic [cbm_pkg::ROM_BANK_W-1:0]      remainder
);
  import cbm_pkg::*;

  logic                   busy;
  logic                   done;
  logic [STEP_W-1:0]      step;
  logic [ROM_BANK_W-1:0]  dvd;
  logic [ROM_COUNT_W-1:0] dvs;
  logic [ROM_COUNT_W-1:0] rem;
  logic [ROM_COUNT_W-1:0] rem_next;
  logic [ROM_COUNT_W:0]   trial;
  logic [ROM_COUNT_W:0]   diff;

  always_comb begin
    trial = {rem, dvd[ROM_BANK_W-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      rem_next = diff[ROM_COUNT_W-1:0];
    end else begin
      rem_next = trial[ROM_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(ROM_BANK_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= (divisor == '0) ? ROM_COUNT_W'(1) : divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[ROM_BANK_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign remainder   = rem[ROM_BANK_W-1:0];

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("remainder unit did not start");
  assert property (@(posedge clk) disable iff (rst) done |-> rem < dvs)
    else $error("remainder not below divisor");
  assert property (@(posedge clk) disable iff (rst)
    busy && step == '0 && !start |=> done && !busy)
    else $error("remainder unit did not finish after last step");
`endif

endmodule

FILE: sv/cartridge_bank_mapper.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Bank controller for a game cartridge bus: register writes, ROM and RAM
// address translation, RAM access gating and rumble motor control.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid, req_stall, req) carries one bus access. It is
//   taken only while the block is idle; req_stall stays high until the
//   result of the previous transaction is loaded into the output register.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns one result for every
//   request, in order. The output register holds it while rsp_stall is high;
//   a new request is taken meanwhile, and its result waits in the sequencer.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the bank
//   count and rumble registers; cfg_ready is always high.
// Transaction flow:
//   A ROM read at 0x4000-0x7FFF runs the bank number through the remainder
//   unit, one bank bit per cycle, before its result is loaded. Every other
//   access goes straight to loading its result. A new request is taken only
//   after the result of the current one is in the output register.
// Reset (rst, synchronous): control state, bank registers and configuration
//   return to their reset values; the output register is emptied.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  cbm_pkg::req_t                      req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output cbm_pkg::rsp_t                      rsp,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cbm_pkg::*;

  state_t                 state;
  state_t                 state_next;
  req_t                   item;
  logic [ROM_COUNT_W-1:0] rom_bank_count;
  logic [RAM_COUNT_W-1:0] ram_bank_count;
  logic                   rumble_present;
  logic [NIBBLE_W-1:0]    ram_enable_nibble;
  logic [NIBBLE_W-1:0]    ram_enable_nibble_next;
  logic [ROM_BANK_W-1:0]  rom_bank;
  logic [ROM_BANK_W-1:0]  rom_bank_next;
  logic [RAM_BANK_W-1:0]  ram_bank;
  logic [RAM_BANK_W-1:0]  ram_bank_next;
  logic                   rumble_motor;
  logic                   rumble_motor_next;
  logic [RAM_BANK_W-1:0]  ram_bank_load;
  rsp_t                   result;
  logic                   accept;
  logic                   needs_div;
  logic                   div_start;
  logic                   finish;
  div_status_t            div_status;
  logic [ROM_BANK_W-1:0]  div_rem;

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && !req_stall;
  assign needs_div = (req.action == ACT_ROM_READ) && (req.address > ROM_LOW_LAST)
                     && (req.address <= ROM_HIGH_LAST);

  cbm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rom_bank),
    .divisor   (rom_bank_count),
    .status    (div_status),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = needs_div ? ST_DIVIDE : ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (div_status.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != ST_IDLE);
    div_start = (state == ST_IDLE) && accept && needs_div;
    finish    = (state == ST_FINISH) && (!rsp_valid || !rsp_stall);
  end

  always_comb begin
    ram_enable_nibble_next = ram_enable_nibble;
    rom_bank_next          = rom_bank;
    ram_bank_next          = ram_bank;
    rumble_motor_next      = rumble_motor;
    ram_bank_load          = ram_bank;
    result                 = '0;
    case (item.action)
      ACT_ROM_READ: begin
        if (item.address <= ROM_LOW_LAST) begin
          result.mapped_address = MAPPED_W'(item.address);
          result.granted        = 1'b1;
        end else if (item.address <= ROM_HIGH_LAST) begin
          result.mapped_address = {div_rem, item.address[ROM_OFS_W-1:0]};
          result.granted        = 1'b1;
        end
      end
      ACT_ROM_WRITE: begin
        result.granted = 1'b1;
        if (item.address <= RAMEN_LAST) begin
          ram_enable_nibble_next = item.write_data[NIBBLE_W-1:0];
        end else if (item.address <= BANK_LO_LAST) begin
          rom_bank_next = {rom_bank[ROM_BANK_W-1], item.write_data};
        end else if (item.address <= BANK_HI_LAST) begin
          rom_bank_next = {item.write_data[0], rom_bank[ROM_BANK_W-2:0]};
        end else if (item.address <= RAM_BANK_LAST) begin
          if (item.write_data <= RAM_BANK_MAX) begin
            ram_bank_load = item.write_data[RAM_BANK_W-1:0];
          end
          ram_bank_next = ram_bank_load;
          if (rumble_present) begin
            rumble_motor_next = ram_bank_load[RAM_BANK_W-1];
            ram_bank_next     = {1'b0, ram_bank_load[RAM_BANK_W-2:0]};
          end
        end
      end
      default: begin
        if (ram_enable_nibble == RAM_ENABLE_KEY && ram_bank_count != '0) begin
          result.granted = 1'b1;
          if (ram_bank_count > RAM_COUNT_W'(1)) begin
            result.mapped_address = MAPPED_W'({ram_bank, item.address[RAM_OFS_W-1:0]});
          end else begin
            result.mapped_address = MAPPED_W'(item.address[RAM_OFS_W-1:0]);
          end
        end
      end
    endcase
    result.rumble_on = rumble_motor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      rsp_valid         <= 1'b0;
      rom_bank_count    <= ROM_COUNT_RESET;
      ram_bank_count    <= RAM_COUNT_RESET;
      rumble_present    <= 1'b0;
      ram_enable_nibble <= '0;
      rom_bank          <= ROM_BANK_RESET;
      ram_bank          <= '0;
      rumble_motor      <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        rsp_valid         <= 1'b1;
        ram_enable_nibble <= ram_enable_nibble_next;
        rom_bank          <= rom_bank_next;
        ram_bank          <= ram_bank_next;
        rumble_motor      <= rumble_motor_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_ROM_BANK_COUNT: rom_bank_count <= cfg_data;
          CFG_RAM_BANK_COUNT: ram_bank_count <= cfg_data[RAM_COUNT_W-1:0];
          CFG_RUMBLE_PRESENT: rumble_present <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (finish) begin
      rsp <= result;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    accept && needs_div |=> state == ST_DIVIDE && div_status.busy)
    else $error("upper ROM read did not enter the remainder unit");
  assert property (@(posedge clk) disable iff (rst)
    finish && item.action == ACT_ROM_WRITE |=> rsp_valid && rsp.granted)
    else $error("ROM write transaction not granted");
  assert property (@(posedge clk) disable iff (rst)
    finish && (item.action == ACT_RAM_READ || item.action == ACT_RAM_WRITE)
    && ram_enable_nibble != RAM_ENABLE_KEY |=> !rsp.granted)
    else $error("RAM transaction granted while RAM disabled");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE |-> div_status.busy || div_status.done)
    else $error("sequencer waits on an idle remainder unit");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cartridge bank mapper. A short table of bus
// accesses and register writes covers the address window edges, every access
// type and the bank/rumble corner cases, then random accesses run under
// several bank-count settings and three sender/receiver idle mixes. Results
// are checked in order against the table or a built-in bank-state predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import cbm_pkg::*;

  localparam int unsigned ROM_WINDOW    = 16384;
  localparam int unsigned RAM_WINDOW    = 8192;
  localparam logic [ADDR_W-1:0] ROM_HIGH_BASE = 16'h4000;
  localparam logic [ADDR_W-1:0] BANK_LO_BASE  = 16'h2000;
  localparam logic [ADDR_W-1:0] BANK_HI_BASE  = 16'h3000;
  localparam logic [ADDR_W-1:0] RAM_WIN_BASE  = 16'hA000;
  localparam logic [ADDR_W-1:0] RAM_WIN_LAST  = 16'hBFFF;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int CHUNKS        = 5;
  localparam int CHUNK_ITEMS   = 103;

  typedef struct {
    bit                    is_cfg;
    cfg_index_t            reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    req_t                  acc;
    bit                    known;
    rsp_t                  want;
  } plan_row_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_t                   req       = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_t                   rsp;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // predictor copy of configuration and bank state
  logic [ROM_COUNT_W-1:0] rom_banks_cfg;
  logic [RAM_COUNT_W-1:0] ram_banks_cfg;
  logic                   rumble_cfg;
  logic [NIBBLE_W-1:0]    ram_key;
  logic [ROM_BANK_W-1:0]  rom_bank_sel;
  logic [RAM_BANK_W-1:0]  ram_bank_sel;
  logic                   motor_bit;

  rsp_t        pending_results[$];
  plan_row_t   access_plan[$];
  int          mismatch_count = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  bit          hold_armed     = 1'b0;
  int          hold_left      = 0;

  cartridge_bank_mapper dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("** cartridge_bank_mapper: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic rsp_t map_access(req_t a);
    rsp_t        res;
    int unsigned modulus;
    int unsigned ofs;
    res = '0;
    case (a.action)
      ACT_ROM_READ: begin
        if (a.address <= ROM_LOW_LAST) begin
          res.mapped_address = MAPPED_W'(a.address);
          res.granted        = 1'b1;
        end else if (a.address <= ROM_HIGH_LAST) begin
          modulus = (rom_banks_cfg == '0) ? 1 : int'(rom_banks_cfg);
          ofs     = int'(a.address - ROM_HIGH_BASE);
          res.mapped_address = MAPPED_W'(ofs + (int'(rom_bank_sel) % modulus) * ROM_WINDOW);
          res.granted        = 1'b1;
        end
      end
      ACT_ROM_WRITE: begin
        if (a.address <= RAMEN_LAST) begin
          ram_key = a.write_data[NIBBLE_W-1:0];
        end else if (a.address <= BANK_LO_LAST) begin
          rom_bank_sel[7:0] = a.write_data;
        end else if (a.address <= BANK_HI_LAST) begin
          rom_bank_sel[8] = a.write_data[0];
        end else if (a.address <= RAM_BANK_LAST) begin
          if (a.write_data <= RAM_BANK_MAX) ram_bank_sel = a.write_data[RAM_BANK_W-1:0];
          if (rumble_cfg) begin
            motor_bit       = ram_bank_sel[3];
            ram_bank_sel[3] = 1'b0;
          end
        end
        res.granted = 1'b1;
      end
      default: begin
        if (ram_key == RAM_ENABLE_KEY && ram_banks_cfg != '0) begin
          ofs = int'(a.address[RAM_OFS_W-1:0]);
          if (ram_banks_cfg > 1) ofs = ofs + int'(ram_bank_sel) * RAM_WINDOW;
          res.mapped_address = MAPPED_W'(ofs);
          res.granted        = 1'b1;
        end
      end
    endcase
    res.rumble_on = motor_bit;
    return res;
  endfunction

  function automatic req_t make_access();
    req_t        a;
    int unsigned pick;
    a.address    = ADDR_W'($urandom);
    a.write_data = DATA_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      a.action = ACT_ROM_READ;
      if ($urandom_range(3) != 0) a.address = ADDR_W'($urandom_range(ROM_HIGH_LAST, ROM_HIGH_BASE));
    end else if (pick < 62) begin
      a.action = ACT_ROM_WRITE;
      case ($urandom_range(4))
        0: begin
          a.address = ADDR_W'($urandom_range(RAMEN_LAST));
          if ($urandom_range(2) != 0) a.write_data[NIBBLE_W-1:0] = RAM_ENABLE_KEY;
        end
        1: a.address = ADDR_W'($urandom_range(BANK_LO_LAST, BANK_LO_BASE));
        2: a.address = ADDR_W'($urandom_range(BANK_HI_LAST, BANK_HI_BASE));
        3: begin
          a.address = ADDR_W'($urandom_range(RAM_BANK_LAST, ROM_HIGH_BASE));
          if ($urandom_range(3) != 0) a.write_data = DATA_W'($urandom_range(RAM_BANK_MAX));
        end
        default: ;
      endcase
    end else begin
      a.action = ($urandom_range(1) != 0) ? ACT_RAM_WRITE : ACT_RAM_READ;
      if ($urandom_range(3) != 0) a.address = ADDR_W'($urandom_range(RAM_WIN_LAST, RAM_WIN_BASE));
    end
    return a;
  endfunction

  function automatic void plan_cfg(cfg_index_t sel, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{is_cfg: 1'b1, reg_sel: sel, reg_val: val, acc: '0, known: 1'b0, want: '0};
    access_plan.push_back(row);
  endfunction

  function automatic void plan_access(action_t act, logic [ADDR_W-1:0] adr,
                                      logic [DATA_W-1:0] dat);
    plan_row_t row;
    row = '{is_cfg: 1'b0, reg_sel: CFG_UNUSED, reg_val: '0, acc: '{act, adr, dat},
            known: 1'b0, want: '0};
    access_plan.push_back(row);
  endfunction

  function automatic void plan_known(action_t act, logic [ADDR_W-1:0] adr,
                                     logic [DATA_W-1:0] dat, logic [MAPPED_W-1:0] m,
                                     logic g, logic r);
    plan_row_t row;
    row = '{is_cfg: 1'b0, reg_sel: CFG_UNUSED, reg_val: '0, acc: '{act, adr, dat},
            known: 1'b1, want: '{m, g, r}};
    access_plan.push_back(row);
  endfunction

  task automatic send_access(req_t a, bit known, rsp_t typed);
    rsp_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= a;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    want = map_access(a);
    if (known) want = typed;
    pending_results.push_back(want);
  endtask

  // drop valid, wait out every pending result, then let the block settle
  task automatic settle_block();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t sel, logic [CFG_DATA_W-1:0] val);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (sel)
      CFG_ROM_BANK_COUNT: rom_banks_cfg = val;
      CFG_RAM_BANK_COUNT: ram_banks_cfg = val[RAM_COUNT_W-1:0];
      CFG_RUMBLE_PRESENT: rumble_cfg    = val[0];
      default: ;
    endcase
  endtask

  task automatic shuffle_config();
    logic [CFG_DATA_W-1:0] rom_n;
    logic [CFG_DATA_W-1:0] ram_n;
    case ($urandom_range(6))
      0:       rom_n = '0;
      1:       rom_n = 10'd1;
      2:       rom_n = 10'd2;
      3:       rom_n = 10'd512;
      4:       rom_n = 10'h3FF;
      default: rom_n = CFG_DATA_W'($urandom_range(512, 1));
    endcase
    case ($urandom_range(5))
      0:       ram_n = '0;
      1:       ram_n = 10'd1;
      2:       ram_n = 10'd16;
      3:       ram_n = {5'($urandom), 5'($urandom)};
      default: ram_n = CFG_DATA_W'($urandom_range(16));
    endcase
    write_reg(CFG_ROM_BANK_COUNT, rom_n);
    write_reg(CFG_RAM_BANK_COUNT, ram_n);
    write_reg(CFG_RUMBLE_PRESENT, CFG_DATA_W'($urandom));
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // receiver: random stall, or a long hold-off when armed
  always @(posedge clk) begin
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no pending transaction", rsp));
      end else begin
        want = pending_results.pop_front();
        if (rsp.mapped_address !== want.mapped_address)
          report_mismatch($sformatf("mapped_address expected %h got %h",
                                    want.mapped_address, rsp.mapped_address));
        if (rsp.granted !== want.granted)
          report_mismatch($sformatf("granted expected %b got %b", want.granted, rsp.granted));
        if (rsp.rumble_on !== want.rumble_on)
          report_mismatch($sformatf("rumble_on expected %b got %b",
                                    want.rumble_on, rsp.rumble_on));
      end
    end
  end

  initial begin
    plan_row_t row;
    rom_banks_cfg = ROM_COUNT_RESET;
    ram_banks_cfg = RAM_COUNT_RESET;
    rumble_cfg    = 1'b0;
    ram_key       = '0;
    rom_bank_sel  = ROM_BANK_RESET;
    ram_bank_sel  = '0;
    motor_bit     = 1'b0;

    // reset configuration: two ROM banks, no RAM, no rumble
    plan_known (ACT_ROM_READ,  16'h0000, 8'h00, 23'h0000, 1'b1, 1'b0);
    plan_known (ACT_ROM_READ,  16'h3FFF, 8'hFF, 23'h3FFF, 1'b1, 1'b0);
    plan_known (ACT_ROM_READ,  16'h4000, 8'h00, 23'h4000, 1'b1, 1'b0);
    plan_known (ACT_ROM_READ,  16'h7FFF, 8'h00, 23'h7FFF, 1'b1, 1'b0);
    plan_known (ACT_ROM_READ,  16'h8000, 8'h00, 23'h0000, 1'b0, 1'b0);
    plan_known (ACT_ROM_READ,  16'hFFFF, 8'h00, 23'h0000, 1'b0, 1'b0);
    plan_known (ACT_RAM_READ,  16'hA000, 8'h00, 23'h0000, 1'b0, 1'b0);
    plan_known (ACT_ROM_WRITE, 16'h0000, 8'h0A, 23'h0000, 1'b1, 1'b0);
    plan_known (ACT_RAM_WRITE, 16'hBFFF, 8'hFF, 23'h0000, 1'b0, 1'b0);
    plan_known (ACT_ROM_WRITE, 16'h2000, 8'hFF, 23'h0000, 1'b1, 1'b0);
    plan_known (ACT_ROM_WRITE, 16'h3FFF, 8'h01, 23'h0000, 1'b1, 1'b0);
    plan_access(ACT_ROM_READ,  16'h4001, 8'h00);
    plan_known (ACT_ROM_WRITE, 16'h2FFF, 8'h00, 23'h0000, 1'b1, 1'b0);
    plan_access(ACT_ROM_READ,  16'h5555, 8'h00);
    plan_known (ACT_ROM_WRITE, 16'h3000, 8'hFE, 23'h0000, 1'b1, 1'b0);
    plan_known (ACT_ROM_WRITE, 16'h6000, 8'hAA, 23'h0000, 1'b1, 1'b0);
    // zero ROM banks, single RAM bank, rumble fitted
    plan_cfg(CFG_ROM_BANK_COUNT, 10'd0);
    plan_cfg(CFG_RAM_BANK_COUNT, 10'd1);
    plan_cfg(CFG_RUMBLE_PRESENT, 10'd1);
    plan_cfg(CFG_UNUSED,         10'h3FF);
    plan_known (ACT_ROM_WRITE, 16'h2000, 8'h07, 23'h0000, 1'b1, 1'b0);
    plan_access(ACT_ROM_READ,  16'h7FFF, 8'h00);
    plan_known (ACT_ROM_WRITE, 16'h4000, 8'h0F, 23'h0000, 1'b1, 1'b1);
    plan_access(ACT_RAM_READ,  16'h0000, 8'h00);
    plan_known (ACT_ROM_WRITE, 16'h5FFF, 8'h80, 23'h0000, 1'b1, 1'b0);
    // widest counts, no rumble
    plan_cfg(CFG_ROM_BANK_COUNT, 10'h3FF);
    plan_cfg(CFG_RAM_BANK_COUNT, 10'd16);
    plan_cfg(CFG_RUMBLE_PRESENT, 10'd0);
    plan_known (ACT_ROM_WRITE, 16'h4000, 8'h0C, 23'h0000, 1'b1, 1'b0);
    plan_access(ACT_RAM_WRITE, 16'hBFFF, 8'h5A);
    plan_known (ACT_ROM_WRITE, 16'h3FFF, 8'h01, 23'h0000, 1'b1, 1'b0);
    plan_access(ACT_ROM_READ,  16'h7FFF, 8'h00);
    plan_known (ACT_ROM_WRITE, 16'h1FFF, 8'hF0, 23'h0000, 1'b1, 1'b0);
    plan_known (ACT_RAM_READ,  16'h1234, 8'h00, 23'h0000, 1'b0, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (access_plan[i]) begin
      row = access_plan[i];
      if (row.is_cfg) write_reg(row.reg_sel, row.reg_val);
      else send_access(row.acc, row.known, row.want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 56 : 0;
      rx_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 30 : 0;
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        shuffle_config();
        for (int n = 0; n < CHUNK_ITEMS; n++) begin
          if (phase == 0 && chunk == 2 && n == 10) hold_armed = 1'b1;
          if (phase == 1 && chunk == 3 && n == 50) settle_block();
          send_access(make_access(), 1'b0, '0);
        end
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("** cartridge_bank_mapper: PASSED **");
    end else begin
      $display("** cartridge_bank_mapper: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/cbm_pkg.sv
sv/cbm_mod_unit.sv
sv/cartridge_bank_mapper.sv
dv/tb_top.sv
